@@ rtl/nn_act_pkg.sv @@
// Shared constants and types of the activation unit.
`timescale 1ns / 1ps

package nn_act_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;
    localparam int KIND_W         = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_SIGMOID  = 3'd0,
        KIND_RELU     = 3'd1,
        KIND_TANH     = 3'd2,
        KIND_LINEAR   = 3'd3,
        KIND_SOFTSIGN = 3'd4,
        KIND_STEP     = 3'd5
    } kind_t;

endpackage

@@ rtl/nn_act_if.sv @@
// Valid/ready channel interfaces of the activation unit.
`timescale 1ns / 1ps

interface nn_act_in_if #(
    parameter int DATA_WIDTH = nn_act_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] x;
    logic                         func;

    modport source (output valid, output x, output func, input ready);
    modport sink   (input valid, input x, input func, output ready);
endinterface

interface nn_act_out_if #(
    parameter int DATA_WIDTH = nn_act_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] y;

    modport source (output valid, output y, input ready);
    modport sink   (input valid, input y, output ready);
endinterface

interface nn_act_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [nn_act_pkg::KIND_W-1:0]  activation_kind;

    modport source (output valid, output activation_kind, input ready);
    modport sink   (input valid, input activation_kind, output ready);
endinterface

@@ rtl/nn_activation_unit_core.sv @@
// Top level of the pipelined neural-network activation unit.
`timescale 1ns / 1ps
//
// Channels: din carries one operand x (signed, FRAC_BITS fraction bits) and
// a selector func (0 activation, 1 derivative); dout returns one result y.
// cfg writes the activation kind; it is always ready and should only be
// written while no transfer is in flight.
// Throughput: one item per cycle while the skid buffer is empty; the defaults
// give Q4.12 operands. The depth is set by the softsign path, two restoring
// divisions with one quotient bit per pipeline stage; every item walks the
// same stages so order is kept.
// When the receiver stalls, the output register holds its result and the
// pipeline keeps moving, so din stays ready until the next result lands in
// a one-entry skid buffer; after that the whole pipeline freezes and
// nothing is lost.
// Reset clears all valid bits, empties the output and skid registers and
// sets the activation kind to sigmoid.
module nn_activation_unit_core #(
    parameter int DATA_WIDTH = nn_act_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = nn_act_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    nn_act_in_if.sink    din,
    nn_act_out_if.source dout,
    nn_act_cfg_if.sink   cfg
);
    import nn_act_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int BW   = (DW > F + 1) ? DW : F + 1;
    localparam int IW   = BW + 3;
    localparam int SW   = IW + 2;
    localparam int PW   = 2 * IW;
    localparam int Q1   = F + 1;
    localparam int DWD  = BW + 1;
    localparam int RW   = DWD + 1;
    localparam int NW   = (2 * F + 1 > DW + F) ? 2 * F + 1 : DW + F;
    localparam int N2W  = Q1 + F;
    localparam int NDIV = 2 * Q1;

    localparam logic signed [IW-1:0] ONE_I = {{(IW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [PW-1:0] ONE_P = {{(PW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic [SW-1:0] ONE_S = {{(SW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic [SW-1:0] C2_S  = SW'(2) << F;
    localparam logic [SW-1:0] C5_S  = SW'(5) << F;
    localparam logic [SW-1:0] C19_S = SW'(19) << F;
    localparam logic [SW-1:0] C27_S = SW'(27) << F;
    localparam logic signed [PW-1:0] MAX_P = signed'(PW'({1'b0, {(DW-1){1'b1}}}));
    localparam logic signed [PW-1:0] MIN_P = -MAX_P - PW'(1);

    typedef struct packed {
        logic                  neg;
        logic                  func;
        kind_t                 kind;
        logic signed [DW-1:0]  yns;
        logic [DWD-1:0]        d;
        logic [RW-1:0]         rem;
        logic [Q1-1:0]         nsh;
        logic [Q1-1:0]         q;
        logic [Q1-1:0]         q1;
    } div_t;

    // Piecewise-linear sigmoid.
    function automatic logic signed [IW-1:0] sig_fn(input logic signed [IW-1:0] a);
        logic [SW-1:0] am;
        logic [SW-1:0] s;
        am = SW'(unsigned'(a[IW-1] ? -a : a));
        if (am >= C5_S)
            s = ONE_S;
        else if ((am << 3) >= C19_S)
            s = (am + C27_S) >> 5;
        else if (am >= ONE_S)
            s = (am + C5_S) >> 3;
        else
            s = (am + C2_S) >> 2;
        if (a[IW-1])
            return ONE_I - signed'(IW'(s));
        else
            return signed'(IW'(s));
    endfunction

    function automatic logic signed [DW-1:0] sat_fn(input logic signed [PW-1:0] v);
        if (v > MAX_P)
            return MAX_P[DW-1:0];
        else if (v < MIN_P)
            return MIN_P[DW-1:0];
        else
            return v[DW-1:0];
    endfunction

    // One restoring division step: returns the new remainder and the quotient bit.
    function automatic logic [RW:0] dstep(input logic [RW-1:0] rem, input logic nb,
                                          input logic [DWD-1:0] d);
        logic [RW-1:0] r2;
        r2 = {rem[RW-2:0], nb};
        if (r2 >= {1'b0, d})
            return {r2 - {1'b0, d}, 1'b1};
        else
            return {r2, 1'b0};
    endfunction

    // Configuration register.
    kind_t kind_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kind_reg <= KIND_SIGMOID;
        else if (cfg.valid)
            kind_reg <= kind_t'(cfg.activation_kind);
    end

    // Output register and skid buffer; the pipeline advances while the skid is empty.
    logic                 out_vld_reg, skid_vld_reg;
    logic signed [DW-1:0] out_y_reg, skid_y_reg;
    logic                 adv;

    assign adv       = !skid_vld_reg;
    assign din.ready = adv;

    // Stage 1: captured operand.
    logic                 v1_reg;
    logic signed [DW-1:0] x1_reg;
    logic                 f1_reg;
    kind_t                k1_reg;

    // Stage 2: forward value and multiplier operands.
    logic                 v2_reg;
    logic signed [IW-1:0] fwd2_reg, ma2_reg, mb2_reg;
    logic [DW-1:0]        m2_reg;
    logic                 neg2_reg, f2_reg;
    kind_t                k2_reg;
    logic signed [IW-1:0] fwd2_next, ma2_next, mb2_next;
    logic [DW-1:0]        m2_next;

    // Stage 3: product.
    logic                 v3_reg;
    logic signed [PW-1:0] prod3_reg;
    logic signed [IW-1:0] fwd3_reg;
    logic [DW-1:0]        m3_reg;
    logic                 neg3_reg, f3_reg;
    kind_t                k3_reg;

    // Division pipeline; entry 0 holds the non-softsign result and the divider setup.
    logic dvv_reg [0:NDIV];
    div_t dv_reg  [0:NDIV];
    div_t dv_next [0:NDIV];

    always_comb
    begin
        logic signed [IW-1:0] xe;
        logic signed [IW-1:0] arg;
        logic signed [IW-1:0] sg;
        logic signed [IW-1:0] t;
        xe  = signed'({{(IW-DW){x1_reg[DW-1]}}, x1_reg});
        arg = (k1_reg == KIND_TANH) ? (xe <<< 1) : xe;
        sg  = sig_fn(arg);
        t   = (sg <<< 1) - ONE_I;
        m2_next = x1_reg[DW-1] ? DW'(-xe) : DW'(xe);
        case (k1_reg)
            KIND_SIGMOID: fwd2_next = sg;
            KIND_RELU:    fwd2_next = xe[IW-1] ? '0 : ((xe > ONE_I) ? ONE_I : xe);
            KIND_TANH:    fwd2_next = t;
            KIND_LINEAR:  fwd2_next = xe;
            KIND_STEP:    fwd2_next = xe[IW-1] ? '0 : ONE_I;
            default:      fwd2_next = '0;
        endcase
        if (k1_reg == KIND_TANH)
        begin
            ma2_next = t;
            mb2_next = t;
        end
        else
        begin
            ma2_next = xe;
            mb2_next = ONE_I - xe;
        end
    end

    always_comb
    begin
        logic signed [PW-1:0] yv;
        logic [NW-1:0]        n1;
        if (!f3_reg)
            yv = PW'(fwd3_reg);
        else
        begin
            case (k3_reg)
                KIND_SIGMOID: yv = prod3_reg >>> F;
                KIND_RELU:    yv = neg3_reg ? '0 : ONE_P;
                KIND_TANH:    yv = ONE_P - (prod3_reg >>> F);
                KIND_LINEAR:  yv = ONE_P;
                default:      yv = '0;
            endcase
        end
        n1 = f3_reg ? (NW'(1) << (2 * F)) : (NW'(m3_reg) << F);
        dv_next[0].neg  = neg3_reg;
        dv_next[0].func = f3_reg;
        dv_next[0].kind = k3_reg;
        dv_next[0].yns  = sat_fn(yv);
        dv_next[0].d    = DWD'(ONE_S) + DWD'(m3_reg);
        dv_next[0].rem  = RW'(n1 >> Q1);
        dv_next[0].nsh  = n1[Q1-1:0];
        dv_next[0].q    = '0;
        dv_next[0].q1   = '0;
    end

    for (genvar j = 1; j <= NDIV; j++)
    begin : g_div
        always_comb
        begin
            div_t           src;
            logic [N2W-1:0] n2;
            logic [RW:0]    st;
            src = dv_reg[j-1];
            n2  = N2W'(dv_reg[j-1].q) << F;
            // Second division starts from the first quotient: r * ONE / d.
            if (j == Q1 + 1)
            begin
                src.q1  = dv_reg[j-1].q;
                src.rem = RW'(n2 >> Q1);
                src.nsh = n2[Q1-1:0];
                src.q   = '0;
            end
            st = dstep(src.rem, src.nsh[Q1-1], src.d);
            dv_next[j]     = src;
            dv_next[j].rem = st[RW:1];
            dv_next[j].nsh = src.nsh << 1;
            dv_next[j].q   = {src.q[Q1-2:0], st[0]};
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int i = 0; i <= NDIV; i++)
                dvv_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg     <= din.valid;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            dvv_reg[0] <= v3_reg;
            for (int i = 1; i <= NDIV; i++)
                dvv_reg[i] <= dvv_reg[i-1];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg    <= din.x;
            f1_reg    <= din.func;
            k1_reg    <= kind_reg;
            fwd2_reg  <= fwd2_next;
            ma2_reg   <= ma2_next;
            mb2_reg   <= mb2_next;
            m2_reg    <= m2_next;
            neg2_reg  <= x1_reg[DW-1];
            f2_reg    <= f1_reg;
            k2_reg    <= k1_reg;
            prod3_reg <= ma2_reg * mb2_reg;
            fwd3_reg  <= fwd2_reg;
            m3_reg    <= m2_reg;
            neg3_reg  <= neg2_reg;
            f3_reg    <= f2_reg;
            k3_reg    <= k2_reg;
            for (int i = 0; i <= NDIV; i++)
                dv_reg[i] <= dv_next[i];
        end
    end

    // Final selection.
    logic signed [DW-1:0] y_fin;
    logic                 push;

    always_comb
    begin
        logic signed [PW-1:0] sv;
        sv = '0;
        if (dv_reg[NDIV].func)
            sv = signed'(PW'(dv_reg[NDIV].q));
        else if (dv_reg[NDIV].neg)
            sv = -signed'(PW'(dv_reg[NDIV].q1));
        else
            sv = signed'(PW'(dv_reg[NDIV].q1));
        if (dv_reg[NDIV].kind == KIND_SOFTSIGN)
            y_fin = sat_fn(sv);
        else
            y_fin = dv_reg[NDIV].yns;
    end

    assign push = adv && dvv_reg[NDIV];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || dout.ready)
        begin
            out_vld_reg  <= skid_vld_reg || push;
            skid_vld_reg <= 1'b0;
        end
        else if (push)
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || dout.ready)
            out_y_reg <= skid_vld_reg ? skid_y_reg : y_fin;
        else if (push)
            skid_y_reg <= y_fin;
    end

    assign dout.valid = out_vld_reg;
    assign dout.y     = out_y_reg;

endmodule

@@ rtl/nn_act_chk.sv @@
// Port-level assertion checker of the activation unit and its bind.
`timescale 1ns / 1ps

module nn_act_chk #(
    parameter int DATA_WIDTH = nn_act_pkg::DATA_WIDTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  din_ready,
    input logic                  dout_valid,
    input logic                  dout_ready,
    input logic [DATA_WIDTH-1:0] dout_y,
    input logic                  cfg_ready
);

    // The input side only closes after the output has been stalled.
    a_ready_after_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !din_ready |-> $past(dout_valid && !dout_ready))
        else $error("din.ready dropped without an output stall");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg.ready low");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout_ready |=> dout_valid)
        else $error("dout.valid dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout_ready |=> $stable(dout_y))
        else $error("dout.y changed while stalled");

endmodule

bind nn_activation_unit_core nn_act_chk #(.DATA_WIDTH(DATA_WIDTH)) u_nn_act_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .din_ready  (din.ready),
    .dout_valid (dout.valid),
    .dout_ready (dout.ready),
    .dout_y     (dout.y),
    .cfg_ready  (cfg.ready)
);
